// ===== rtl/epoch_seconds_to_calendar_macros.svh =====
// assertion macros used by the port-level checker file
`ifndef EPOCH_SECONDS_TO_CALENDAR_MACROS_SVH
`define EPOCH_SECONDS_TO_CALENDAR_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ES2CAL_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define ES2CAL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/es2cal_pkg.sv =====
// constants and helpers for the epoch seconds to calendar converter
`timescale 1ns / 1ps
`default_nettype none

package es2cal_pkg;

	// field widths
	localparam int EPOCH_W  = 31;
	localparam int IN_TDATA_W  = 32;
	localparam int OUT_TDATA_W = 40;
	localparam int YEAR_W   = 11;
	localparam int MONTH_W  = 4;
	localparam int DOM_W    = 5;
	localparam int HOUR_W   = 5;
	localparam int MIN_W    = 6;
	localparam int SEC_W    = 6;
	localparam int WDAY_W   = 3;
	localparam int DAYS_W   = 15;

	// width of the shared subtractor
	localparam int ALU_W = 31;

	// divisors and calendar constants
	localparam int SECS_PER_DAY  = 86400;
	localparam int SECS_PER_HOUR = 3600;
	localparam int SECS_PER_MIN  = 60;
	localparam int DAYS_PER_WEEK = 7;
	localparam int DAYS_LEAP     = 366;
	localparam int DAYS_COMMON   = 365;
	localparam int WDAY_OFFSET   = 4;

	localparam logic [YEAR_W-1:0]  FIRST_YEAR     = 11'd1970;
	localparam logic [MONTH_W-1:0] LAST_MONTH_IDX = 4'd11;

	// top shift of each restoring division
	localparam logic [3:0] DAY_K  = 4'd14;
	localparam logic [3:0] HOUR_K = 4'd4;
	localparam logic [3:0] MIN_K  = 4'd5;
	localparam logic [3:0] WDAY_K = 4'd12;

	// month length, index from 0 for january
	function automatic logic [DOM_W-1:0] days_in_month(input logic [MONTH_W-1:0] idx,
		input logic leap);
		logic [DOM_W-1:0] d;
		case (idx) inside
			4'd1:                    d = leap ? 5'd29 : 5'd28;
			4'd3, 4'd5, 4'd8, 4'd10: d = 5'd30;
			default:                 d = 5'd31;
		endcase
		return d;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/es2cal_alu.sv =====
// shared subtract and compare unit
`timescale 1ns / 1ps
`default_nettype none

module es2cal_alu #(
	parameter int W = es2cal_pkg::ALU_W
) (
	input  wire logic [W-1:0] a,
	input  wire logic [W-1:0] b,
	output logic      [W-1:0] diff,
	output logic              ge
);

	logic borrow;

	// one wide subtract, borrow gives the compare
	assign {borrow, diff} = {1'b0, a} - {1'b0, b};
	assign ge = ~borrow;

endmodule

`default_nettype wire

// ===== rtl/epoch_seconds_to_calendar.sv =====
// epoch seconds to calendar date: sequencer around one shared subtractor
// steps: restoring divisions of 15, 5, 6 and 13 steps for days, hours, minutes and
//   weekday, then one subtraction per year and per month
// a request is taken only while idle; the output register lets the next
//   request in while a result waits, a stalled result holds the month step
// reset: arst_n clears sequencer state and the output valid; payload is not reset
`timescale 1ns / 1ps
`default_nettype none

module epoch_seconds_to_calendar #(
	parameter int ALU_W = es2cal_pkg::ALU_W
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// [30:0] epoch_seconds, [31] zero pad
	input  wire logic [es2cal_pkg::IN_TDATA_W-1:0]  s_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// [10:0] year, [14:11] month, [19:15] day_of_month, [24:20] hour,
	// [30:25] minute, [36:31] second, [39:37] weekday
	output logic [es2cal_pkg::OUT_TDATA_W-1:0] m_tdata
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DAYS = 3'd1;
	localparam logic [2:0] ST_HOUR = 3'd2;
	localparam logic [2:0] ST_MINS = 3'd3;
	localparam logic [2:0] ST_WDAY = 3'd4;
	localparam logic [2:0] ST_YEAR = 3'd5;
	localparam logic [2:0] ST_MNTH = 3'd6;

	logic [2:0]                              state_q;
	logic                                    m_tvalid_q;
	logic [ALU_W-1:0]                        rem_q;
	logic [es2cal_pkg::DAYS_W-1:0]           quo_q;
	logic [3:0]                              k_q;
	logic [es2cal_pkg::DAYS_W-1:0]           days_q;
	logic [es2cal_pkg::HOUR_W-1:0]           hour_q;
	logic [es2cal_pkg::MIN_W-1:0]            min_q;
	logic [es2cal_pkg::SEC_W-1:0]            sec_q;
	logic [es2cal_pkg::WDAY_W-1:0]           wday_q;
	logic [es2cal_pkg::YEAR_W-1:0]           year_q;
	logic [es2cal_pkg::MONTH_W-1:0]          mon_q;
	logic [es2cal_pkg::OUT_TDATA_W-1:0]      m_tdata_q;

	logic [ALU_W-1:0]                        alu_b;
	logic [ALU_W-1:0]                        alu_diff;
	logic                                    alu_ge;
	logic [ALU_W-1:0]                        rem_nx;
	logic [es2cal_pkg::DAYS_W-1:0]           quo_nx;
	logic                                    leap;
	logic                                    mon_take;
	logic                                    done;
	logic                                    out_load;
	logic [es2cal_pkg::MONTH_W-1:0]          month_out;
	logic [es2cal_pkg::DOM_W-1:0]            dom_out;

	// subtrahend per phase
	assign leap = (year_q[1:0] == 2'b00);
	always_comb begin
		unique case (state_q)
			ST_DAYS: alu_b = ALU_W'(es2cal_pkg::SECS_PER_DAY) << k_q;
			ST_HOUR: alu_b = ALU_W'(es2cal_pkg::SECS_PER_HOUR) << k_q;
			ST_MINS: alu_b = ALU_W'(es2cal_pkg::SECS_PER_MIN) << k_q;
			ST_WDAY: alu_b = ALU_W'(es2cal_pkg::DAYS_PER_WEEK) << k_q;
			ST_YEAR: alu_b = leap ? ALU_W'(es2cal_pkg::DAYS_LEAP)
				: ALU_W'(es2cal_pkg::DAYS_COMMON);
			ST_MNTH: alu_b = ALU_W'(es2cal_pkg::days_in_month(mon_q, leap));
			default: alu_b = '0;
		endcase
	end

	es2cal_alu #(.W(ALU_W)) u_alu (
		.a    (rem_q),
		.b    (alu_b),
		.diff (alu_diff),
		.ge   (alu_ge)
	);

	// restoring division step and month walk
	assign rem_nx   = alu_ge ? alu_diff : rem_q;
	assign quo_nx   = {quo_q[es2cal_pkg::DAYS_W-2:0], alu_ge};
	assign mon_take = (mon_q != es2cal_pkg::LAST_MONTH_IDX) && alu_ge;
	assign done     = (state_q == ST_MNTH) && !mon_take;
	assign out_load = done && (!m_tvalid_q || m_tready);

	assign month_out = mon_q + 4'd1;
	assign dom_out   = rem_q[es2cal_pkg::DOM_W-1:0] + 5'd1;

	// sequencer and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (s_tvalid) state_q <= ST_DAYS;
				ST_DAYS: if (k_q == 4'd0) state_q <= ST_HOUR;
				ST_HOUR: if (k_q == 4'd0) state_q <= ST_MINS;
				ST_MINS: if (k_q == 4'd0) state_q <= ST_WDAY;
				ST_WDAY: if (k_q == 4'd0) state_q <= ST_YEAR;
				ST_YEAR: if (!alu_ge) state_q <= ST_MNTH;
				ST_MNTH: if (out_load) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				rem_q <= ALU_W'(s_tdata[es2cal_pkg::EPOCH_W-1:0]);
				quo_q <= '0;
				k_q   <= es2cal_pkg::DAY_K;
			end
			ST_DAYS: begin
				rem_q <= rem_nx;
				quo_q <= quo_nx;
				k_q   <= k_q - 4'd1;
				if (k_q == 4'd0) begin
					days_q <= quo_nx;
					quo_q  <= '0;
					k_q    <= es2cal_pkg::HOUR_K;
				end
			end
			ST_HOUR: begin
				rem_q <= rem_nx;
				quo_q <= quo_nx;
				k_q   <= k_q - 4'd1;
				if (k_q == 4'd0) begin
					hour_q <= quo_nx[es2cal_pkg::HOUR_W-1:0];
					quo_q  <= '0;
					k_q    <= es2cal_pkg::MIN_K;
				end
			end
			ST_MINS: begin
				rem_q <= rem_nx;
				quo_q <= quo_nx;
				k_q   <= k_q - 4'd1;
				if (k_q == 4'd0) begin
					min_q <= quo_nx[es2cal_pkg::MIN_W-1:0];
					sec_q <= rem_nx[es2cal_pkg::SEC_W-1:0];
					rem_q <= ALU_W'(days_q) + ALU_W'(es2cal_pkg::WDAY_OFFSET);
					k_q   <= es2cal_pkg::WDAY_K;
				end
			end
			ST_WDAY: begin
				rem_q <= rem_nx;
				k_q   <= k_q - 4'd1;
				if (k_q == 4'd0) begin
					wday_q <= rem_nx[es2cal_pkg::WDAY_W-1:0];
					rem_q  <= ALU_W'(days_q);
					year_q <= es2cal_pkg::FIRST_YEAR;
				end
			end
			ST_YEAR: begin
				if (alu_ge) begin
					rem_q  <= alu_diff;
					year_q <= year_q + 11'd1;
				end else begin
					mon_q <= '0;
				end
			end
			ST_MNTH: begin
				if (mon_take) begin
					rem_q <= alu_diff;
					mon_q <= mon_q + 4'd1;
				end
			end
			default: begin
			end
		endcase
		if (out_load) begin
			m_tdata_q <= {wday_q, sec_q, min_q, hour_q, dom_out, month_out, year_q};
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

`default_nettype wire

// ===== rtl/es2cal_chk.sv =====
// port-level checker for the epoch seconds to calendar converter
`timescale 1ns / 1ps
`default_nettype none
`include "epoch_seconds_to_calendar_macros.svh"

module es2cal_chk (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	input wire logic s_tready,
	input wire logic m_tvalid,
	input wire logic m_tready,
	input wire logic [es2cal_pkg::OUT_TDATA_W-1:0] m_tdata
);

	// busy after taking a request
	`ES2CAL_ASSERT_NEXT(a_busy_after_req, clk, arst_n, s_tvalid && s_tready, !s_tready, "ready after request")

	// stalled result holds
	`ES2CAL_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")

	// date fields in range
	`ES2CAL_ASSERT_NOW(a_date_range, clk, arst_n, m_tvalid, (m_tdata[14:11] >= 4'd1) && (m_tdata[14:11] <= 4'd12) && (m_tdata[19:15] != 5'd0) && (m_tdata[39:37] <= 3'd6) && (m_tdata[10:0] >= 11'd1970) && (m_tdata[10:0] <= 11'd2038), "date field out of range")

	// time fields in range
	`ES2CAL_ASSERT_NOW(a_time_range, clk, arst_n, m_tvalid, (m_tdata[24:20] <= 5'd23) && (m_tdata[30:25] <= 6'd59) && (m_tdata[36:31] <= 6'd59), "time field out of range")

endmodule

bind epoch_seconds_to_calendar es2cal_chk u_es2cal_chk (.*);

`default_nettype wire

// ===== dv/tb_top.sv =====
// testbench for the epoch seconds to calendar converter
`timescale 1ns / 1ps

module tb_top;
	import es2cal_pkg::*;

	// one converted date, laid out as on m_tdata, most significant field first
	typedef struct packed {
		logic [WDAY_W-1:0]  weekday;
		logic [SEC_W-1:0]   second;
		logic [MIN_W-1:0]   minute;
		logic [HOUR_W-1:0]  hour;
		logic [DOM_W-1:0]   day_of_month;
		logic [MONTH_W-1:0] month;
		logic [YEAR_W-1:0]  year;
	} calendar_t;

	localparam int RANDOM_REQUESTS = 2000;
	localparam int DRAIN_EARLY     = 20;
	localparam int DRAIN_LATE      = 1000;
	localparam int TAIL_CYCLES     = 130;
	localparam int MAX_SHOWN       = 10;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_TDATA_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;

	logic [EPOCH_W-1:0] epoch_pending[$];
	calendar_t calendar_due[$];
	int sent_cnt = 0;
	int got_cnt = 0;
	int err_cnt = 0;
	int tx_gap = 0;
	int rx_stall = 0;

	int unsigned month_len[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

	epoch_seconds_to_calendar dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	// expected date for a count of seconds
	function automatic calendar_t to_calendar(input logic [EPOCH_W-1:0] secs);
		int unsigned days, sod, left, yr, mon, ylen, mlen;
		calendar_t c;
		days = secs / SECS_PER_DAY;
		sod = secs % SECS_PER_DAY;
		left = days;
		yr = 1970;
		ylen = DAYS_COMMON;
		while (left >= ylen) begin
			left -= ylen;
			yr++;
			ylen = (yr % 4 == 0) ? DAYS_LEAP : DAYS_COMMON;
		end
		mon = 0;
		mlen = month_len[0];
		while (mon < 11 && left >= mlen) begin
			left -= mlen;
			mon++;
			mlen = month_len[mon] + ((mon == 1 && yr % 4 == 0) ? 1 : 0);
		end
		c.year = yr[YEAR_W-1:0];
		c.month = 4'(mon + 1);
		c.day_of_month = 5'(left + 1);
		c.hour = 5'(sod / SECS_PER_HOUR);
		c.minute = 6'((sod % SECS_PER_HOUR) / SECS_PER_MIN);
		c.second = 6'(sod % SECS_PER_MIN);
		c.weekday = 3'((days + WDAY_OFFSET) % DAYS_PER_WEEK);
		return c;
	endfunction

	// seconds count of a calendar date and time, month and day from 1
	function automatic logic [EPOCH_W-1:0] epoch_at(input int unsigned yr, input int unsigned mon,
		input int unsigned dd, input int unsigned hh, input int unsigned mi,
		input int unsigned ss);
		int unsigned days, y, m;
		days = 0;
		for (y = 1970; y < yr; y++)
			days += (y % 4 == 0) ? DAYS_LEAP : DAYS_COMMON;
		for (m = 0; m + 1 < mon; m++)
			days += month_len[m] + ((m == 1 && yr % 4 == 0) ? 1 : 0);
		days += dd - 1;
		return EPOCH_W'(days * SECS_PER_DAY + hh * SECS_PER_HOUR + mi * SECS_PER_MIN + ss);
	endfunction

	// idle length: mostly none or short, now and then long
	function automatic int pick_gap(input bit quiet);
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 45)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		return $urandom_range(6, 24);
	endfunction

	function automatic string show(input calendar_t c);
		return $sformatf("%0d-%0d-%0d %0d:%0d:%0d wd%0d", c.year, c.month, c.day_of_month,
			c.hour, c.minute, c.second, c.weekday);
	endfunction

	// random request, biased toward day, month and year boundaries
	function automatic logic [EPOCH_W-1:0] random_epoch();
		int unsigned r, yr, mon, dd, mlen;
		r = $urandom_range(0, 9);
		if (r < 4)
			return EPOCH_W'($urandom());
		if (r < 7) begin
			case ($urandom_range(0, 4))
				0: return EPOCH_W'($urandom_range(0, 24854) * SECS_PER_DAY);
				1: return EPOCH_W'($urandom_range(1, 24855) * SECS_PER_DAY - 1);
				2: return EPOCH_W'($urandom_range(0, 24854) * SECS_PER_DAY
					+ $urandom_range(0, 23) * SECS_PER_HOUR + $urandom_range(0, 1) * 3599);
				default: return EPOCH_W'($urandom_range(0, 24854) * SECS_PER_DAY
					+ $urandom_range(0, SECS_PER_DAY - 1));
			endcase
		end
		if (r < 9) begin
			yr = $urandom_range(1970, 2037);
			mon = $urandom_range(1, 12);
			mlen = month_len[mon-1] + ((mon == 2 && yr % 4 == 0) ? 1 : 0);
			dd = $urandom_range(0, 1) ? 1 : mlen;
			if ($urandom_range(0, 1))
				return epoch_at(yr, mon, dd, 0, 0, $urandom_range(0, 2));
			return epoch_at(yr, mon, dd, 23, 59, $urandom_range(57, 59));
		end
		return EPOCH_W'(32'h7FFF_FFFF - $urandom_range(0, 2000000));
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			tx_gap <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				calendar_due.push_back(to_calendar(s_tdata[EPOCH_W-1:0]));
				sent_cnt++;
			end
			if (!s_tvalid || s_tready) begin
				if (tx_gap > 0) begin
					s_tvalid <= 1'b0;
					tx_gap <= tx_gap - 1;
				end else if ((sent_cnt == DRAIN_EARLY || sent_cnt == DRAIN_LATE)
					&& calendar_due.size() != 0) begin
					// hold off until the block has delivered everything
					s_tvalid <= 1'b0;
				end else if (epoch_pending.size() != 0) begin
					s_tvalid <= 1'b1;
					s_tdata <= {1'b0, epoch_pending.pop_front()};
					tx_gap <= pick_gap((sent_cnt / 150) % 4 == 1);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// result monitor and receiver back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_stall <= 0;
		end else if (m_tvalid && m_tready) begin
			if (calendar_due.size() == 0) begin
				err_cnt++;
				if (err_cnt <= MAX_SHOWN)
					$display("unexpected result %s", show(calendar_t'(m_tdata)));
			end else if (calendar_t'(m_tdata) !== calendar_due[0]) begin
				err_cnt++;
				if (err_cnt <= MAX_SHOWN)
					$display("result %0d: expected %s, got %s", got_cnt,
						show(calendar_due[0]), show(calendar_t'(m_tdata)));
			end
			if (calendar_due.size() != 0)
				void'(calendar_due.pop_front());
			got_cnt++;
			rx_stall <= pick_gap((got_cnt / 170) % 5 == 2);
			m_tready <= (pick_gap(1'b0) == 0);
		end else if (rx_stall > 0) begin
			rx_stall <= rx_stall - 1;
			m_tready <= (rx_stall == 1);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// stimulus, reset and end of run
	initial begin
		epoch_pending.push_back('0);
		epoch_pending.push_back('1);
		epoch_pending.push_back(EPOCH_W'(SECS_PER_DAY - 1));
		epoch_pending.push_back(EPOCH_W'(SECS_PER_DAY));
		epoch_pending.push_back(epoch_at(1970, 12, 31, 23, 59, 59));
		epoch_pending.push_back(epoch_at(1971, 2, 28, 23, 59, 59));
		epoch_pending.push_back(epoch_at(1972, 2, 29, 0, 0, 0));
		epoch_pending.push_back(epoch_at(2000, 2, 29, 6, 30, 30));
		epoch_pending.push_back(epoch_at(2038, 1, 1, 0, 0, 0));
		epoch_pending.push_back(31'h5555_5555);
		epoch_pending.push_back(31'h2AAA_AAAA);
		epoch_pending.push_back(31'h4000_0000);
		// last second of every month of a leap year
		for (int m = 1; m <= 12; m++)
			epoch_pending.push_back(epoch_at(2024, m, month_len[m-1] + ((m == 2) ? 1 : 0),
				23, 59, 59));
		for (int i = 0; i < RANDOM_REQUESTS; i++)
			epoch_pending.push_back(random_epoch());

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (epoch_pending.size() != 0 || s_tvalid || calendar_due.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		@(negedge clk);
		if (err_cnt == 0 && calendar_due.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	// watchdog
	initial begin
		#10_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
